// ----- design/dmx_rx_pkg.sv -----
// ----------------------------------------------------------------------------
// dmx_rx_pkg
// Shared types and constants of the DMX512 frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dmx_rx_pkg;

  // Frame and channel store geometry
  localparam int CHANNELS      = 512;
  localparam int FRAME_MAX     = 513;
  localparam int LEN_W         = $clog2(FRAME_MAX + 1);
  localparam int FR_AW         = $clog2(FRAME_MAX);
  localparam int CH_AW         = $clog2(CHANNELS);
  localparam int CHECK_MIN_LEN = 100;

  localparam logic [31:0] DEFAULT_DEBOUNCE = 32'd160000;

  // Input opcodes
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_BREAK = 2'd1;
  localparam logic [1:0] OP_OVF   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 1'd1;

  // Input item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [31:0] timestamp;
    logic [8:0]  channel_index;
  } item_t;

  // Result item
  typedef struct packed {
    logic        frame_done;
    logic        break_accepted;
    logic [9:0]  channel_count;
    logic [7:0]  start_code;
    logic [7:0]  xor_check;
    logic [15:0] sum_check;
    logic        check_valid;
    logic [7:0]  read_data;
  } res_t;

  // Frame store port request
  typedef struct packed {
    logic             we;
    logic [FR_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic [FR_AW-1:0] raddr;
  } frm_req_t;

  // Channel store port request
  typedef struct packed {
    logic             we;
    logic [CH_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic [CH_AW-1:0] raddr;
  } chn_req_t;

  // Checksum unit control
  typedef struct packed {
    logic       clr;
    logic       en;
    logic [7:0] data;
  } chk_ctl_t;

endpackage

`default_nettype wire

// ----- design/dmx_rx_if.sv -----
// ----------------------------------------------------------------------------
// dmx_rx_if
// Valid/ready channels of the DMX512 frame receiver: input items, result
// items and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmx_rx_item_if;
  logic                 valid;
  logic                 ready;
  dmx_rx_pkg::item_t    item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface dmx_rx_res_if;
  logic                 valid;
  logic                 ready;
  dmx_rx_pkg::res_t     res;

  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

interface dmx_rx_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [dmx_rx_pkg::CFG_IDX_W-1:0]     index;
  logic [31:0]                          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/dmx_rx_ram.sv -----
// ----------------------------------------------------------------------------
// dmx_rx_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_rx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/dmx_rx_chk.sv -----
// ----------------------------------------------------------------------------
// dmx_rx_chk
// Checksum unit: XOR and 16-bit wrapping sum, one byte per cycle while enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_rx_chk (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dmx_rx_pkg::chk_ctl_t ctl_i,
  output      logic [7:0]           xor_o,
  output      logic [15:0]          sum_o
);
  import dmx_rx_pkg::*;

  logic [7:0]  xor_q, xor_d;
  logic [15:0] sum_q, sum_d;

  // Accumulate on enable, clear at frame start
  always_comb begin
    xor_d = xor_q;
    sum_d = sum_q;
    if (ctl_i.clr) begin
      xor_d = '0;
      sum_d = '0;
    end else if (ctl_i.en) begin
      xor_d = xor_q ^ ctl_i.data;
      sum_d = sum_q + {8'd0, ctl_i.data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q <= '0;
      sum_q <= '0;
    end else begin
      xor_q <= xor_d;
      sum_q <= sum_d;
    end
  end

  assign xor_o = xor_q;
  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- design/dmx_rx_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmx_rx_ctrl
// Sequencer of the DMX512 frame receiver: framing state, break debounce,
// frame copy loop, channel reads and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_rx_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input items
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire dmx_rx_pkg::item_t                   in_item_i,
  // result items
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      dmx_rx_pkg::res_t                    out_res_o,
  // configuration writes
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [dmx_rx_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [31:0]                         cfg_data_i,
  // frame store
  output      dmx_rx_pkg::frm_req_t                frm_req_o,
  input  wire logic [7:0]                          frm_rdata_i,
  // channel store
  output      dmx_rx_pkg::chn_req_t                chn_req_o,
  input  wire logic [7:0]                          chn_rdata_i,
  // checksum unit
  output      dmx_rx_pkg::chk_ctl_t                chk_ctl_o,
  input  wire logic [7:0]                          xor_i,
  input  wire logic [15:0]                         sum_i
);
  import dmx_rx_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_COPY   = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]       state_q, state_d;
  item_t            item_q, item_d;
  res_t             res_q, res_d;
  res_t             out_res_q, out_res_d;
  logic             out_valid_q, out_valid_d;

  logic             rx_en_q, rx_en_d;
  logic [31:0]      deb_q, deb_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             frame_open_q, frame_open_d;
  logic             synced_q, synced_d;
  logic [31:0]      last_q, last_d;
  logic [LEN_W-1:0] fill_q, fill_d;

  logic [LEN_W-1:0] copy_len_q, copy_len_d;
  logic [LEN_W-1:0] ptr_q, ptr_d;
  logic [LEN_W-1:0] paddr_q, paddr_d;
  logic             pend_q, pend_d;

  logic [31:0]      brk_diff;
  logic             brk_ignore;
  logic [LEN_W-1:0] ch_off;
  logic [LEN_W-1:0] n_chan;
  logic [LEN_W-1:0] n_store;
  logic [LEN_W-1:0] idx_ext;

  // Debounce distance, modular
  assign brk_diff   = item_q.timestamp - last_q;
  assign brk_ignore = (last_q != '0) && (brk_diff < deb_q);

  assign ch_off  = paddr_q - LEN_W'(1);
  assign n_chan  = copy_len_q - LEN_W'(1);
  assign n_store = (n_chan > LEN_W'(CHANNELS)) ? LEN_W'(CHANNELS) : n_chan;
  assign idx_ext = LEN_W'(item_q.channel_index);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    res_d        = res_q;
    out_res_d    = out_res_q;
    out_valid_d  = out_valid_q;
    rx_en_d      = rx_en_q;
    deb_d        = deb_q;
    len_d        = len_q;
    frame_open_d = frame_open_q;
    synced_d     = synced_q;
    last_d       = last_q;
    fill_d       = fill_q;
    copy_len_d   = copy_len_q;
    ptr_d        = ptr_q;
    paddr_d      = paddr_q;
    pend_d       = 1'b0;

    frm_req_o       = '0;
    frm_req_o.raddr = ptr_q[FR_AW-1:0];
    chn_req_o       = '0;
    chn_req_o.raddr = item_q.channel_index[CH_AW-1:0];
    chk_ctl_o       = '0;
    chk_ctl_o.data  = frm_rdata_i;

    // Configuration writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RX_ENABLE: begin
          rx_en_d = cfg_data_i[0];
          if (cfg_data_i[0]) begin
            frame_open_d = 1'b0;
            len_d        = '0;
            synced_d     = 1'b0;
            last_d       = '0;
          end
        end
        CFG_DEBOUNCE: deb_d = cfg_data_i;
        default: ;
      endcase
    end

    // Result register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          res_d   = '0;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_OUT;
        if (item_q.opcode == OP_READ) begin
          state_d = ST_RDWAIT;
        end else if (rx_en_q) begin
          case (item_q.opcode)
            OP_DATA: begin
              if (frame_open_q && (len_q < LEN_W'(FRAME_MAX))) begin
                frm_req_o.we    = 1'b1;
                frm_req_o.waddr = len_q[FR_AW-1:0];
                frm_req_o.wdata = item_q.data_byte;
                len_d           = len_q + LEN_W'(1);
              end
            end
            OP_OVF: begin
              frame_open_d = 1'b0;
              len_d        = '0;
            end
            OP_BREAK: begin
              if (!brk_ignore) begin
                last_d               = item_q.timestamp;
                res_d.break_accepted = 1'b1;
                len_d                = '0;
                frame_open_d         = 1'b1;
                copy_len_d           = len_q;
                if (frame_open_q && (len_q != '0)) begin
                  if (!synced_q) begin
                    synced_d = 1'b1;
                  end else if (len_q >= LEN_W'(2)) begin
                    ptr_d         = '0;
                    chk_ctl_o.clr = 1'b1;
                    state_d       = ST_COPY;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      // Channel store read data is registered and arrives the cycle after its address
      ST_RDWAIT: begin
        if ((idx_ext < LEN_W'(CHANNELS)) && (idx_ext < fill_q)) begin
          res_d.read_data = chn_rdata_i;
        end
        state_d = ST_OUT;
      end

      // Read frame bytes in order; the byte read last cycle is consumed now
      ST_COPY: begin
        if (ptr_q < copy_len_q) begin
          ptr_d   = ptr_q + LEN_W'(1);
          pend_d  = 1'b1;
          paddr_d = ptr_q;
        end
        if (pend_q) begin
          if (paddr_q == '0) begin
            res_d.start_code = frm_rdata_i;
          end else begin
            chk_ctl_o.en = 1'b1;
            if (ch_off < LEN_W'(CHANNELS)) begin
              chn_req_o.we    = 1'b1;
              chn_req_o.waddr = ch_off[CH_AW-1:0];
              chn_req_o.wdata = frm_rdata_i;
            end
          end
          if (paddr_q == n_chan) begin
            pend_d              = 1'b0;
            res_d.frame_done    = 1'b1;
            res_d.channel_count = n_chan;
            res_d.check_valid   = (copy_len_q >= LEN_W'(CHECK_MIN_LEN));
            if (n_store > fill_q) begin
              fill_d = n_store;
            end
            state_d = ST_FIN;
          end
        end
      end

      // Checksums settle in the cycle after the last byte
      ST_FIN: begin
        res_d.xor_check = xor_i;
        res_d.sum_check = sum_i;
        state_d         = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_res_d   = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      rx_en_q      <= 1'b1;
      deb_q        <= DEFAULT_DEBOUNCE;
      len_q        <= '0;
      frame_open_q <= 1'b0;
      synced_q     <= 1'b0;
      last_q       <= '0;
      fill_q       <= '0;
      pend_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      rx_en_q      <= rx_en_d;
      deb_q        <= deb_d;
      len_q        <= len_d;
      frame_open_q <= frame_open_d;
      synced_q     <= synced_d;
      last_q       <= last_d;
      fill_q       <= fill_d;
      pend_q       <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    res_q      <= res_d;
    out_res_q  <= out_res_d;
    copy_len_q <= copy_len_d;
    ptr_q      <= ptr_d;
    paddr_q    <= paddr_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

// ----- design/dmx512_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// dmx512_frame_receiver_unit
// Data, overflow, disabled items and breaks that deliver nothing pass the execute
// and output states; channel reads add a wait state for the registered channel
// store read. An accepted break that delivers a frame runs the copy loop, which
// reads one frame byte per cycle through the frame store's read port.
// One item is in work at a time; the next is accepted once the sequencer is
// idle, even while the previous result waits in the output register.
// Reset is asynchronous: framing state clears, rx_enable is 1, the debounce is
// 160000; the channel store reads zero until a frame writes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx512_frame_receiver_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  dmx_rx_item_if.sink     item_i,
  dmx_rx_res_if.source    res_o,
  dmx_rx_cfg_if.sink      cfg_i
);
  import dmx_rx_pkg::*;

  frm_req_t   frm_req;
  chn_req_t   chn_req;
  chk_ctl_t   chk_ctl;
  logic [7:0] frm_rdata;
  logic [7:0] chn_rdata;
  logic [7:0] xor_val;
  logic [15:0] sum_val;

  // Sequencer
  dmx_rx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .in_item_i   (item_i.item),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_res_o   (res_o.res),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .frm_req_o   (frm_req),
    .frm_rdata_i (frm_rdata),
    .chn_req_o   (chn_req),
    .chn_rdata_i (chn_rdata),
    .chk_ctl_o   (chk_ctl),
    .xor_i       (xor_val),
    .sum_i       (sum_val)
  );

  // Active frame store
  dmx_rx_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_MAX)
  ) u_frm_ram (
    .clk_i   (clk_i),
    .we_i    (frm_req.we),
    .waddr_i (frm_req.waddr),
    .wdata_i (frm_req.wdata),
    .raddr_i (frm_req.raddr),
    .rdata_o (frm_rdata)
  );

  // Channel store
  dmx_rx_ram #(
    .WIDTH (8),
    .DEPTH (CHANNELS)
  ) u_chn_ram (
    .clk_i   (clk_i),
    .we_i    (chn_req.we),
    .waddr_i (chn_req.waddr),
    .wdata_i (chn_req.wdata),
    .raddr_i (chn_req.raddr),
    .rdata_o (chn_rdata)
  );

  // Checksum unit
  dmx_rx_chk u_chk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (chk_ctl),
    .xor_o  (xor_val),
    .sum_o  (sum_val)
  );

endmodule

`default_nettype wire

// ----- design/dmx_rx_checker.sv -----
// ----------------------------------------------------------------------------
// dmx_rx_checker
// Port-level assertions of the DMX512 frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_rx_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire dmx_rx_pkg::res_t res_i
);
  import dmx_rx_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(res_i)))
    else $error("result changed while stalled");

  // One item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("item accepted while busy");

  // A delivered frame needs an accepted break
  a_done_brk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && res_i.frame_done) |-> res_i.break_accepted)
    else $error("frame done without accepted break");

  // Frame fields are zero unless a frame was delivered
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !res_i.frame_done) |->
      (res_i.channel_count == '0 && res_i.start_code == '0 &&
       res_i.xor_check == '0 && res_i.sum_check == '0 && !res_i.check_valid))
    else $error("frame fields set without frame");

  // Check valid only for frames of 100 bytes or more
  a_chk_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && res_i.check_valid) |->
      (res_i.channel_count >= 10'(CHECK_MIN_LEN - 1)))
    else $error("check valid on short frame");

endmodule

bind dmx512_frame_receiver_unit dmx_rx_checker u_dmx_rx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .res_i       (res_o.res)
);

`default_nettype wire

// ----- tb/dmx_frame_check_pkg.sv -----
// ----------------------------------------------------------------------------
// dmx_frame_check_pkg
// Frame predictor and result scoreboard for the DMX512 frame receiver bench.
// Mirrors framing, sync, break debounce and the channel store, and compares
// each result item against the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

package dmx_frame_check_pkg;

  import dmx_rx_pkg::*;

  class dmx_frame_predictor;

    // Shadow copy of the receiver state
    logic [7:0]  frame_buf [FRAME_MAX];
    logic [7:0]  chan_mem  [CHANNELS];
    int          buf_len;
    bit          frame_open;
    bit          synced;
    logic [31:0] last_break;
    bit          rx_on;
    logic [31:0] debounce;

    res_t        expected_q [$];
    int          mismatches;

    function new();
      foreach (frame_buf[i]) frame_buf[i] = '0;
      foreach (chan_mem[i]) chan_mem[i] = '0;
      clear_framing();
      rx_on      = 1'b1;
      debounce   = DEFAULT_DEBOUNCE;
      mismatches = 0;
    endfunction

    function void clear_framing();
      frame_open = 1'b0;
      buf_len    = 0;
      synced     = 1'b0;
      last_break = '0;
    endfunction

    // Register write, applied at the accepting edge
    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
      if (idx == CFG_RX_ENABLE) begin
        rx_on = val[0];
        if (rx_on) clear_framing();
      end else if (idx == CFG_DEBOUNCE) begin
        debounce = val;
      end
    endfunction

    // Break: debounce, then sync or deliver the frame that just ended
    function void take_break(input logic [31:0] ts, inout res_t r);
      logic [31:0] delta;
      logic [7:0]  xr;
      logic [15:0] sm;
      delta = ts - last_break;
      if (last_break != 0 && delta < debounce) return;
      last_break       = ts;
      r.break_accepted = 1'b1;
      if (frame_open && buf_len > 0) begin
        if (!synced) begin
          synced = 1'b1;
        end else if (buf_len >= 2) begin
          xr = '0;
          sm = '0;
          for (int i = 1; i < buf_len; i++) begin
            xr = xr ^ frame_buf[i];
            sm = sm + 16'(frame_buf[i]);
            if (i - 1 < CHANNELS) chan_mem[i-1] = frame_buf[i];
          end
          r.frame_done    = 1'b1;
          r.channel_count = 10'(buf_len - 1);
          r.start_code    = frame_buf[0];
          r.xor_check     = xr;
          r.sum_check     = sm;
          r.check_valid   = (buf_len >= CHECK_MIN_LEN);
        end
      end
      buf_len    = 0;
      frame_open = 1'b1;
    endfunction

    // Accepted input item: update state, queue the expected result
    function void accept_item(input item_t it);
      res_t r;
      r = '0;
      if (it.opcode == OP_READ) begin
        if (int'(it.channel_index) < CHANNELS) r.read_data = chan_mem[it.channel_index];
      end else if (rx_on) begin
        case (it.opcode)
          OP_DATA: begin
            if (frame_open && buf_len < FRAME_MAX) begin
              frame_buf[buf_len] = it.data_byte;
              buf_len++;
            end
          end
          OP_BREAK: take_break(it.timestamp, r);
          default: begin
            frame_open = 1'b0;
            buf_len    = 0;
          end
        endcase
      end
      expected_q.push_back(r);
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Accepted result item against the oldest expectation
    function void compare_result(input res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no pending expectation");
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      check_field("frame_done",     want.frame_done,     got.frame_done);
      check_field("break_accepted", want.break_accepted, got.break_accepted);
      check_field("channel_count",  want.channel_count,  got.channel_count);
      check_field("start_code",     want.start_code,     got.start_code);
      check_field("xor_check",      want.xor_check,      got.xor_check);
      check_field("sum_check",      want.sum_check,      got.sum_check);
      check_field("check_valid",    want.check_valid,    got.check_valid);
      check_field("read_data",      want.read_data,      got.read_data);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

  endclass

endpackage

`default_nettype wire

// ----- tb/dmx512_frame_receiver_unit_tb.sv -----
// ----------------------------------------------------------------------------
// dmx512_frame_receiver_unit_tb
// Self-checking bench for the DMX512 frame receiver. Directed items cover
// debounce edges, sync, empty, one-byte, aborted and wrapped-time frames;
// random frame traffic then runs under several debounce settings, with
// rx_enable toggled and randomized valid/ready pacing on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx512_frame_receiver_unit_tb;

  import dmx_rx_pkg::*;
  import dmx_frame_check_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  logic clk_i;
  logic rst_ni;

  dmx_rx_item_if item_if ();
  dmx_rx_res_if  res_if ();
  dmx_rx_cfg_if  cfg_if ();

  dmx512_frame_receiver_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  dmx_frame_predictor rx_model;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_req       = 0;
  int          items_sent     = 0;
  int          cycle_cnt      = 0;
  logic [31:0] ts_now         = '0;
  logic [31:0] debounce_now   = DEFAULT_DEBOUNCE;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog
  initial begin
    forever @(posedge clk_i) cycle_cnt++;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls, long hold-off on request, check at the edge
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        res_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready) rx_model.compare_result(res_if.res);
    end
  end

  function automatic item_t mk_item(input logic [1:0] op, input logic [7:0] b,
                                    input logic [31:0] ts, input logic [8:0] idx);
    item_t it;
    it.opcode        = op;
    it.data_byte     = b;
    it.timestamp     = ts;
    it.channel_index = idx;
    return it;
  endfunction

  // Timestamp that clears the debounce window of the last clean break
  function automatic logic [31:0] clean_ts();
    ts_now = ts_now + debounce_now + 32'($urandom_range(0, 40));
    return ts_now;
  endfunction

  // Offer one item, with random idle cycles in front, until accepted
  task automatic send_item(input item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid = 1'b0;
      @(negedge clk_i);
    end
    item_if.item  = it;
    item_if.valid = 1'b1;
    do @(posedge clk_i); while (!item_if.ready);
    rx_model.accept_item(it);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(mk_item(OP_DATA, b, $urandom, 9'($urandom)));
  endtask

  task automatic send_break(input logic [31:0] ts);
    send_item(mk_item(OP_BREAK, 8'($urandom), ts, 9'($urandom)));
  endtask

  task automatic send_ovf();
    send_item(mk_item(OP_OVF, 8'($urandom), $urandom, 9'($urandom)));
  endtask

  task automatic send_read(input logic [8:0] idx);
    send_item(mk_item(OP_READ, 8'($urandom), $urandom, idx));
  endtask

  // Stop offering and wait until every result item is back
  task automatic wait_drain();
    @(negedge clk_i);
    item_if.valid = 1'b0;
    while (rx_model.pending() != 0) @(negedge clk_i);
  endtask

  // Register write; only issued with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait_drain();
    @(negedge clk_i);
    cfg_if.index = idx;
    cfg_if.data  = val;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    rx_model.write_reg(idx, val);
    if (idx == CFG_DEBOUNCE) debounce_now = val;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_pace(input int sidle, input int rstall);
    @(posedge clk_i);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
  endtask

  // Clean break followed by nbytes data bytes, with the odd read or bounce
  task automatic send_frame(input int nbytes);
    send_break(clean_ts());
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(99) < 6) send_read(9'($urandom));
      if ($urandom_range(99) < 2) send_break(ts_now + 32'($urandom_range(1, 500)));
      send_byte(8'($urandom));
    end
  endtask

  // Mostly well-formed frames, plus reads, aborts, bounces and noise
  task automatic run_traffic(input int budget);
    int stop_at;
    int pick;
    int nb;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        nb = ($urandom_range(99) < 80) ? $urandom_range(0, 24) : $urandom_range(98, 120);
        // keep the phase close to its item budget
        if (nb > stop_at - items_sent) nb = stop_at - items_sent;
        send_frame(nb);
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 4)) send_read(9'($urandom));
      end else if (pick < 88) begin
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
        send_ovf();
      end else if (pick < 93) begin
        send_break(ts_now + 32'($urandom_range(0, 2000)));
      end else if (pick < 96) begin
        send_item(mk_item(2'($urandom), 8'($urandom), $urandom, 9'($urandom)));
      end else begin
        wait_drain();
      end
    end
  endtask

  // Main sequence
  initial begin : stimulus
    rx_model       = new();
    rst_ni         = 1'b0;
    item_if.valid  = 1'b0;
    item_if.item   = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset contents, dropped byte, break at time zero
    send_read(9'd0);
    send_read(9'd511);
    send_byte(8'hFF);
    send_break(32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    // no earlier break stored: sync frame, then a bounce
    send_break(32'd5);
    send_break(32'd10);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'hFF);
    // distance equal to the window passes and delivers
    send_break(32'd160005);
    // empty frame, then one-byte frame
    send_break(32'd320005);
    send_byte(8'h7E);
    send_break(32'd480005);
    // overflow aborts; later byte is outside any frame
    send_byte(8'h01);
    send_byte(8'h02);
    send_ovf();
    send_byte(8'h03);
    send_break(32'd640005);
    send_read(9'd0);
    send_read(9'd1);
    // debounce across the 32-bit wrap
    send_break(32'hFFFF_FFFF);
    send_byte(8'h3C);
    send_break(32'd159999);
    ts_now = $urandom;

    // No idling, default window, re-enable clears framing
    write_reg(CFG_RX_ENABLE, 32'd1);
    set_pace(0, 0);
    run_traffic(30);

    // Zero window: every break accepted; sender idles
    write_reg(CFG_DEBOUNCE, 32'd0);
    set_pace(58, 0);
    run_traffic(30);

    // Small window; receiver stalls and holds off for a long stretch
    write_reg(CFG_DEBOUNCE, 32'd1000);
    set_pace(0, 58);
    run_traffic(15);
    send_read(9'($urandom));
    hold_req = HOLD_CYCLES;
    run_traffic(15);

    // Maximum window: breaks after the first are debounced
    write_reg(CFG_DEBOUNCE, 32'hFFFF_FFFF);
    set_pace(24, 24);
    run_traffic(25);

    // Receive off: only reads take effect
    write_reg(CFG_RX_ENABLE, 32'd0);
    run_traffic(15);

    // Receive back on, full-length frame with bytes past the end
    write_reg(CFG_RX_ENABLE, 32'd1);
    write_reg(CFG_DEBOUNCE, 32'd300);
    set_pace(0, 0);
    send_frame(4);
    send_break(clean_ts());
    // high bytes so the 16-bit sum wraps
    repeat (516) send_byte(8'($urandom) | 8'h80);
    send_frame(5);
    set_pace(24, 24);
    run_traffic(25);

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (rx_model.mismatches == 0 && rx_model.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
